>>> rtl/core/bdpc_pkg.sv
// bdpc_pkg: shared types and constants for the button debounce and press classifier
// used by bdpc_button and button_debounce_press_classifier, no dependencies
`default_nettype none

package bdpc_pkg;

  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 1;
  localparam int EV_BITS      = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS = 1'b1;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd1000;

  typedef enum logic [EV_BITS-1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } ev_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_time;
    logic [CFG_BITS-1:0] long_press_time;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/bdpc_button.sv
// bdpc_button: per-button debounce state and short/long press classification
// depends on bdpc_pkg
`default_nettype none

module bdpc_button #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 raw,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire bdpc_pkg::cfg_t       cfg,
  output bdpc_pkg::ev_t             event_code
);

  import bdpc_pkg::*;

  logic                 raw_seen;
  logic                 debounced_level;
  logic [TIME_BITS-1:0] change_stamp;
  logic [TIME_BITS-1:0] press_stamp;
  logic                 long_reported;

  logic                 raw_seen_next;
  logic                 debounced_level_next;
  logic [TIME_BITS-1:0] change_stamp_next;
  logic [TIME_BITS-1:0] press_stamp_next;
  logic                 long_reported_next;

  logic                 changed;
  logic                 accept;
  logic                 is_short;
  logic                 is_long;
  logic [TIME_BITS-1:0] el_change;
  logic [TIME_BITS-1:0] el_press;
  logic [TIME_BITS-1:0] deb_ext;
  logic [TIME_BITS-1:0] long_ext;

  assign deb_ext  = TIME_BITS'(cfg.debounce_time);
  assign long_ext = TIME_BITS'(cfg.long_press_time);

  always_comb begin
    changed           = (raw != raw_seen);
    raw_seen_next     = raw;
    change_stamp_next = changed ? now : change_stamp;
    // differences wrap with the timestamp width
    el_change         = now - change_stamp_next;
    accept            = (el_change >= deb_ext) && (raw != debounced_level);

    debounced_level_next = accept ? raw : debounced_level;
    press_stamp_next     = (accept && raw) ? now : press_stamp;
    long_reported_next   = (accept && raw) ? 1'b0 : long_reported;

    // on release the press stamp is unchanged, so one subtraction serves both checks
    el_press = now - press_stamp_next;
    is_short = accept && !raw && !long_reported && (el_press < long_ext);
    is_long  = debounced_level_next && !long_reported_next && (el_press >= long_ext);
    if (is_long) begin
      long_reported_next = 1'b1;
    end

    if (is_long) begin
      event_code = EV_LONG;
    end else if (is_short) begin
      event_code = EV_SHORT;
    end else begin
      event_code = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_seen        <= 1'b0;
      debounced_level <= 1'b0;
      change_stamp    <= '0;
      press_stamp     <= '0;
      long_reported   <= 1'b0;
    end else if (en) begin
      raw_seen        <= raw_seen_next;
      debounced_level <= debounced_level_next;
      change_stamp    <= change_stamp_next;
      press_stamp     <= press_stamp_next;
      long_reported   <= long_reported_next;
    end
  end

  a_long_marks_reported: assert property (@(posedge clk) disable iff (rst)
    en && event_code == EV_LONG |=> long_reported && debounced_level)
    else $error("long press not recorded");

  a_short_is_release: assert property (@(posedge clk) disable iff (rst)
    en && event_code == EV_SHORT |=> !debounced_level && !long_reported)
    else $error("short press without debounced release");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(debounced_level) && $stable(long_reported) && $stable(press_stamp))
    else $error("button state changed without a transaction");

endmodule

`default_nettype wire

>>> rtl/core/button_debounce_press_classifier.sv
// button_debounce_press_classifier: top level, input register, per-button classifiers,
// result register; depends on bdpc_pkg and bdpc_button
//
//  channel  | direction | handshake           | payload
//  s_*      | in        | s_tvalid / s_tready | s_tdata: time_now, pressed per button
//  m_*      | out       | m_tvalid / m_tready | m_tdata: 2-bit event per button
//  cfg_*    | in        | cfg_we              | cfg_index, cfg_wdata
//
// one poll tick per cycle sustained while results are taken; a tick passes the input register,
// then the classifier logic, into the result register
// the button state updates as a tick moves into the result register
// a stalled result holds the result register; the input register still takes one tick
// rst is synchronous and clears all button state and valids, config returns to 50 / 1000
`default_nettype none

module button_debounce_press_classifier #(
  parameter int NUM_BUTTONS = 2,
  parameter int TIME_BITS   = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [bdpc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [bdpc_pkg::CFG_BITS-1:0]       cfg_wdata,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // time_now [TIME_BITS-1:0], then pressed level of each button, zero padded
  input  wire logic [((TIME_BITS+NUM_BUTTONS+7)/8)*8-1:0] s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // event of each button, 2 bits each from button 0 up, zero padded
  output logic [((2*NUM_BUTTONS+7)/8)*8-1:0]       m_tdata
);

  import bdpc_pkg::*;

  localparam int OUT_W   = ((2*NUM_BUTTONS+7)/8)*8;
  localparam int EV_W    = EV_BITS * NUM_BUTTONS;

  cfg_t cfg;

  logic                   in_valid;
  logic [TIME_BITS-1:0]   in_time;
  logic [NUM_BUTTONS-1:0] in_pressed;
  logic                   res_valid;
  logic [EV_W-1:0]        res_events;
  logic [EV_W-1:0]        events_next;
  logic                   advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time   <= DEBOUNCE_RESET;
      cfg.long_press_time <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   cfg.debounce_time   <= cfg_wdata;
        REG_LONG_PRESS: cfg.long_press_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!res_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_time    <= s_tdata[TIME_BITS-1:0];
      in_pressed <= s_tdata[TIME_BITS +: NUM_BUTTONS];
    end
  end

  for (genvar k = 0; k < NUM_BUTTONS; k++) begin : g_button
    ev_t ev;
    bdpc_button #(
      .TIME_BITS (TIME_BITS)
    ) u_button (
      .clk        (clk),
      .rst        (rst),
      .en         (advance),
      .raw        (in_pressed[k]),
      .now        (in_time),
      .cfg        (cfg),
      .event_code (ev)
    );
    assign events_next[EV_BITS*k +: EV_BITS] = ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_events <= events_next;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = OUT_W'(res_events);

  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("processed tick did not reach the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !m_tready |-> !advance)
    else $error("pending result overwritten");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_time) && $stable(in_pressed))
    else $error("waiting tick lost from the input register");

endmodule

`default_nettype wire

>>> dv/bdpc_press_checker.sv
`timescale 1ns / 100ps
// bdpc_press_checker: watches the poll, result and config ports of the press classifier,
// predicts the events of each poll tick and compares them; depends on bdpc_pkg
module bdpc_press_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bdpc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bdpc_pkg::CFG_BITS-1:0]     cfg_wdata,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  // time_now [31:0], pressed_first [32], pressed_second [33], zero padded
  input  logic [39:0]                       s_tdata,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // event_first [1:0], event_second [3:2], zero padded
  input  logic [7:0]                        m_tdata,
  output int                                mismatches,
  output int                                events_pending
);
  import bdpc_pkg::*;

  typedef struct packed {
    ev_t second;
    ev_t first;
  } poll_events_t;

  logic [CFG_BITS-1:0] debounce_ms;
  logic [CFG_BITS-1:0] long_ms;

  // per-button tracking
  logic [1:0]  raw_lvl;
  logic [1:0]  deb_lvl;
  logic [1:0]  long_done;
  logic [31:0] chg_at [2];
  logic [31:0] press_at [2];

  poll_events_t expected_events [$];
  int           results_seen;

  initial begin
    mismatches     = 0;
    events_pending = 0;
    results_seen   = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want_v);
    $display("%0t: result %0d, %s: got %0d, expected %0d", $time, results_seen, what, got,
             want_v);
    mismatches++;
  endtask

  function automatic poll_events_t classify_tick(input logic [31:0] now, input logic [1:0] lvl);
    ev_t          evs [2];
    logic [31:0]  held;
    logic [31:0]  since_press;
    poll_events_t r;
    for (int k = 0; k < 2; k++) begin
      evs[k] = EV_NONE;
      if (lvl[k] != raw_lvl[k]) begin
        raw_lvl[k] = lvl[k];
        chg_at[k]  = now;
      end
      held = now - chg_at[k];
      if (held >= {16'd0, debounce_ms} && lvl[k] != deb_lvl[k]) begin
        deb_lvl[k] = lvl[k];
        if (lvl[k]) begin
          press_at[k]  = now;
          long_done[k] = 1'b0;
        end else begin
          since_press = now - press_at[k];
          if (!long_done[k] && since_press < {16'd0, long_ms}) evs[k] = EV_SHORT;
        end
      end
      // long press overrides anything found above
      since_press = now - press_at[k];
      if (deb_lvl[k] && !long_done[k] && since_press >= {16'd0, long_ms}) begin
        long_done[k] = 1'b1;
        evs[k] = EV_LONG;
      end
    end
    r.first  = evs[0];
    r.second = evs[1];
    return r;
  endfunction

  always @(posedge clk) begin
    poll_events_t want;
    if (rst) begin
      debounce_ms = DEBOUNCE_RESET;
      long_ms     = LONG_PRESS_RESET;
      raw_lvl     = '0;
      deb_lvl     = '0;
      long_done   = '0;
      for (int k = 0; k < 2; k++) begin
        chg_at[k]   = '0;
        press_at[k] = '0;
      end
      expected_events.delete();
    end else begin
      // results first: a poll accepted on this edge cannot have produced one yet
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          report_mismatch("result with no poll pending", m_tdata, 0);
        end else begin
          want = expected_events.pop_front();
          if (m_tdata[1:0] !== want.first) report_mismatch("event_first", m_tdata[1:0], want.first);
          if (m_tdata[3:2] !== want.second)
            report_mismatch("event_second", m_tdata[3:2], want.second);
          if (m_tdata[7:4] !== 4'd0) report_mismatch("padding", m_tdata[7:4], 0);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE:   debounce_ms = cfg_wdata;
          REG_LONG_PRESS: long_ms     = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_events.push_back(classify_tick(s_tdata[31:0], s_tdata[33:32]));
    end
    events_pending <= expected_events.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// tb: drives poll ticks and config writes into button_debounce_press_classifier and gives
// the verdict; depends on bdpc_pkg, the block and bdpc_press_checker
module tb;
  import bdpc_pkg::*;

  localparam int POLL_W     = ((32 + 2 + 7) / 8) * 8;
  localparam int EVENT_W    = ((2 * 2 + 7) / 8) * 8;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_POLLS = 75;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_DEBOUNCE;
  logic [CFG_BITS-1:0]     cfg_wdata = '0;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [POLL_W-1:0]       s_tdata   = '0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [EVENT_W-1:0]      m_tdata;

  int mismatches;
  int events_pending;

  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  logic [CFG_BITS-1:0] cur_deb = DEBOUNCE_RESET;
  logic [CFG_BITS-1:0] cur_lp  = LONG_PRESS_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_debounce_press_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  bdpc_press_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatches     (mismatches),
    .events_pending (events_pending)
  );

  // entered and left at a falling edge
  task automatic send_poll(input logic [31:0] t, input logic first_lvl, input logic second_lvl);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {6'd0, second_lvl, first_lvl, t};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off polls until every result is back, then let the pipeline settle before returning
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (events_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_BITS-1:0] deb, input logic [CFG_BITS-1:0] lp);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_wdata <= deb;
    @(negedge clk);
    cfg_index <= REG_LONG_PRESS;
    cfg_wdata <= lp;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_deb = deb;
    cur_lp  = lp;
  endtask

  // receiver with random backpressure per transaction
  initial begin
    int stall;
    int taken;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 30 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      stall = rx_steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    logic [CFG_BITS-1:0] phase_deb [NUM_PHASES];
    logic [CFG_BITS-1:0] phase_lp  [NUM_PHASES];
    logic [31:0]         now_ms;
    logic [31:0]         span;
    logic [1:0]          target;
    logic [1:0]          lvl;
    int                  pick;

    phase_deb = '{16'd0, 16'd65535, 16'd3, 16'd0, 16'd12, 16'd20, 16'd65535, 16'd50};
    phase_lp  = '{16'd0, 16'd65535, 16'd40, 16'd25, 16'd0, 16'd150, 16'd0, 16'd1000};
    target    = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: default timing, short and long presses, release after long, wrap and
    // timestamps going backwards
    send_poll(32'd0, 1'b0, 1'b0);
    send_poll(32'd0, 1'b1, 1'b0);
    send_poll(32'd50, 1'b1, 1'b0);
    send_poll(32'd100, 1'b0, 1'b1);
    send_poll(32'd149, 1'b0, 1'b1);
    send_poll(32'd150, 1'b0, 1'b1);
    send_poll(32'd1149, 1'b0, 1'b1);
    send_poll(32'd1150, 1'b0, 1'b1);
    send_poll(32'd1200, 1'b0, 1'b0);
    send_poll(32'd1250, 1'b0, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_poll(32'd49, 1'b1, 1'b1);
    send_poll(32'd48, 1'b1, 1'b1);
    send_poll(32'd100, 1'b0, 1'b0);
    send_poll(32'd150, 1'b0, 1'b0);
    // zero debounce and zero long-press time: a press is long in the tick it is seen
    drain_results();
    set_config(16'd0, 16'd0);
    send_poll(32'd1000, 1'b1, 1'b0);
    send_poll(32'd1000, 1'b0, 1'b1);
    // zero debounce with a short long-press time
    drain_results();
    set_config(16'd0, 16'd100);
    send_poll(32'd7, 1'b1, 1'b1);
    send_poll(32'd8, 1'b0, 1'b1);
    send_poll(32'd107, 1'b0, 1'b1);
    send_poll(32'd108, 1'b0, 1'b0);

    now_ms = $urandom;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      if (p == 5) set_config(16'($urandom_range(0, 100)), 16'($urandom_range(0, 600)));
      else set_config(phase_deb[p], phase_lp[p]);
      span = cur_deb / 2 + cur_lp / 8 + 3;
      for (int i = 0; i < PHASE_POLLS; i++) begin
        if (i % 25 == 0) tx_steady = ($urandom_range(0, 3) == 0);
        if (p == 3 && i == 40) drain_results();
        if ($urandom_range(0, 24) == 0) begin
          // noise: any timestamp, any levels
          now_ms = $urandom;
          lvl    = 2'($urandom_range(0, 3));
        end else begin
          pick = $urandom_range(0, 15);
          if (pick < 2) now_ms = now_ms;
          else if (pick < 12) now_ms = now_ms + $urandom_range(0, span);
          else if (pick < 14)
            now_ms = now_ms + $urandom_range(32'(cur_deb), 32'(cur_deb) + 32'(cur_lp));
          else if (pick == 14) now_ms = now_ms - $urandom_range(1, span);
          else now_ms = now_ms + $urandom;
          if ($urandom_range(0, 5) == 0) target[0] = ~target[0];
          if ($urandom_range(0, 5) == 0) target[1] = ~target[1];
          // occasional contact bounce against the intended level
          lvl = target ^ {($urandom_range(0, 7) == 0), ($urandom_range(0, 7) == 0)};
        end
        send_poll(now_ms, lvl[0], lvl[1]);
      end
    end

    drain_results();
    repeat (6) @(negedge clk);
    if (mismatches == 0 && events_pending == 0) begin
      $display("button_debounce_press_classifier verification clean");
    end else begin
      $display("button_debounce_press_classifier verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("button_debounce_press_classifier verification failed");
    $finish;
  end

endmodule
